>>> rtl/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helpers for the quaternion to Euler angle block.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int CORDIC_LAT    = CORDIC_RUN + 1;
  localparam int SQRT_STEPS    = 29;

  typedef logic signed [35:0] sum_t;
  typedef logic signed [37:0] vec_t;
  typedef logic signed [27:0] ang_t;
  typedef logic        [56:0] sq_t;

  localparam ang_t HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;

  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  // Round a Q24 angle to Q13 (half up) and saturate to +-lim.
  function automatic logic signed [15:0] to_q13(input ang_t z, input logic signed [17:0] lim);
    logic signed [28:0] t;
    logic signed [28:0] s;
    logic signed [17:0] r;
    t = {z[27], z} + 29'sd1024;
    s = t >>> 11;
    r = s[17:0];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

>>> rtl/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qte_isqrt (
  input  logic               clk,
  input  logic               en,
  input  qte_pkg::sq_t       rem,
  output logic        [28:0] root
);
  import qte_pkg::*;

  sq_t n [SQRT_STEPS+1];
  sq_t r [SQRT_STEPS+1];

  assign n[0] = rem;
  assign r[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam sq_t BIT = sq_t'(1) << (2 * (SQRT_STEPS - 1 - k));
    sq_t t;
    assign t = r[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n[k] >= t) begin
          n[k+1] <= n[k] - t;
          r[k+1] <= (r[k] >> 1) + BIT;
        end else begin
          n[k+1] <= n[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  assign root = r[SQRT_STEPS][28:0];

endmodule

>>> rtl/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: four-quadrant arctangent in Q24 radians.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic          clk,
  input  logic          en,
  input  qte_pkg::vec_t x_in,
  input  qte_pkg::vec_t y_in,
  output qte_pkg::ang_t angle
);
  import qte_pkg::*;

  vec_t x [CORDIC_RUN+1];
  vec_t y [CORDIC_RUN+1];
  ang_t z [CORDIC_RUN+1];
  logic zf [CORDIC_RUN+1];

  // Fold the left half plane onto the right one.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x[0] <= y_in;
          y[0] <= -x_in;
          z[0] <= HALF_PI_Q24;
        end else begin
          x[0] <= -y_in;
          y[0] <= x_in;
          z[0] <= -HALF_PI_Q24;
        end
      end else begin
        x[0] <= x_in;
        y[0] <= y_in;
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_TAB[i];
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // Zero vector gives zero angle.
  assign angle = zf[CORDIC_RUN] ? '0 : z[CORDIC_RUN];

endmodule

>>> rtl/quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion (Q2.14) to Z-Y-X roll, pitch and yaw (Q3.13 radians; pitch Q2.13).
// ----------------------------------------------------------------------------
// One quaternion enters and one result leaves per clock while the pipeline
// is not held. The pipeline is made of the product/sum stages, the
// bit-per-stage square root for the pitch cosine and the unrolled CORDIC.
// The whole pipeline advances together; it holds only
// when a result sits at the output and the sink is not ready. Roll and yaw
// are four-quadrant arctangents; pitch is clamped to +-pi/2 with
// pitch_clamped set when |2(wy-zx)| reaches one. The block keeps no state.
module quaternion_to_euler_angles_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31], 0
  output logic [0:0]  m_tuser    // pitch_clamped[0]
);
  import qte_pkg::*;

  localparam int TAIL = SQRT_STEPS + CORDIC_LAT;

  typedef struct packed {
    sum_t sr;
    sum_t cr;
    sum_t sp;
    sum_t sy;
    sum_t cy;
  } side_t;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: products.
  logic v1;
  logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= qw * qx;  yz <= qy * qz;  xx <= qx * qx;
      yy <= qy * qy;  wy <= qw * qy;  zx <= qz * qx;
      wz <= qw * qz;  xy <= qx * qy;  zz <= qz * qz;
    end
  end

  // Stage 2: doubled sums, Q8.28.
  logic  v2;
  side_t s2;
  always_ff @(posedge clk) begin
    if (en) begin
      s2.sr <= 36'(2 * (36'(wx) + 36'(yz)));
      s2.cr <= 36'sd268435456 - 36'(2 * (36'(xx) + 36'(yy)));
      s2.sp <= 36'(2 * (36'(wy) - 36'(zx)));
      s2.sy <= 36'(2 * (36'(wz) + 36'(xy)));
      s2.cy <= 36'sd268435456 - 36'(2 * (36'(yy) + 36'(zz)));
    end
  end

  // Stage 3: pitch sine magnitude, clamp test and square.
  logic        v3;
  side_t       s3;
  logic        clamp3;
  logic [55:0] sq3;
  logic [35:0] mag2;
  assign mag2 = s2.sp[35] ? 36'(-s2.sp) : 36'(s2.sp);

  always_ff @(posedge clk) begin
    if (en) begin
      s3     <= s2;
      clamp3 <= mag2 >= 36'd268435456;
      sq3    <= mag2[27:0] * mag2[27:0];
    end
  end

  // Square root of 1 - s*s gives the Q28 pitch cosine.
  logic [28:0] cosp;
  qte_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rem  ((sq_t'(1) << 56) - sq_t'(sq3)),
    .root (cosp)
  );

  side_t sd [SQRT_STEPS];
  logic  fl [TAIL];
  logic  vl [TAIL];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s3;
      for (int k = 1; k < SQRT_STEPS; k++) sd[k] <= sd[k-1];
      fl[0] <= clamp3;
      for (int k = 1; k < TAIL; k++) fl[k] <= fl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int k = 0; k < TAIL; k++) vl[k] <= 1'b0;
    end else if (en) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      vl[0] <= v3;
      for (int k = 1; k < TAIL; k++) vl[k] <= vl[k-1];
    end
  end

  // Three CORDICs run side by side.
  side_t sa;
  ang_t  z_roll, z_yaw, z_pitch;
  assign sa = sd[SQRT_STEPS-1];

  qte_cordic u_roll (
    .clk (clk), .en (en),
    .x_in (vec_t'(sa.cr)), .y_in (vec_t'(sa.sr)), .angle (z_roll)
  );
  qte_cordic u_yaw (
    .clk (clk), .en (en),
    .x_in (vec_t'(sa.cy)), .y_in (vec_t'(sa.sy)), .angle (z_yaw)
  );
  qte_cordic u_pitch (
    .clk (clk), .en (en),
    .x_in (vec_t'({1'b0, cosp})), .y_in (vec_t'(sa.sp)), .angle (z_pitch)
  );

  // Sign of pitch sine travels along for the clamped case.
  logic sgn [CORDIC_LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      sgn[0] <= sa.sp[35];
      for (int k = 1; k < CORDIC_LAT; k++) sgn[k] <= sgn[k-1];
    end
  end

  // Output register: round, saturate, pack.
  logic signed [15:0] roll_q, yaw_q, pitch_q;
  logic               clamp_o;
  assign roll_q = to_q13(z_roll, PI_Q13);
  assign yaw_q  = to_q13(z_yaw, PI_Q13);
  always_comb begin
    if (fl[TAIL-1]) begin
      pitch_q = sgn[CORDIC_LAT-1] ? -HALF_PI_Q13[15:0] : HALF_PI_Q13[15:0];
    end else begin
      pitch_q = to_q13(z_pitch, HALF_PI_Q13);
    end
  end
  assign clamp_o = fl[TAIL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vl[TAIL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, yaw_q, pitch_q[14:0], roll_q};
      m_tuser <= clamp_o;
    end
  end

  logic signed [15:0] roll_o, yaw_o;
  logic signed [14:0] pitch_o;
  assign roll_o  = m_tdata[15:0];
  assign pitch_o = m_tdata[30:16];
  assign yaw_o   = m_tdata[46:31];

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> pitch_o == 15'sd12868 || pitch_o == -15'sd12868)
    else $error("clamped pitch is not +-pi/2");
  a_roll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> roll_o <= 16'sd25736 && roll_o >= -16'sd25736)
    else $error("roll out of range");
  a_yaw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> yaw_o <= 16'sd25736 && yaw_o >= -16'sd25736)
    else $error("yaw out of range");
  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pitch_o <= 15'sd12868 && pitch_o >= -15'sd12868)
    else $error("pitch out of range");

endmodule
